FILE: design/tee_pkg.sv
package tee_pkg;

  localparam int MAX_ROWS   = 256;
  localparam int MAX_EDGES  = 1024;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int EDGE_W     = $clog2(MAX_EDGES);
  localparam int CNT_W      = $clog2(MAX_EDGES + 1);
  localparam int EDGE_NUM_W = 10;
  localparam int COORD_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int N_SIDES    = 4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_CELL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_REGION_WIDTH  = 3'd2,
    CFG_REGION_HEIGHT = 3'd3,
    CFG_BLOCK_WIDTH   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SIDE_WEST  = 2'd0,
    SIDE_EAST  = 2'd1,
    SIDE_NORTH = 2'd2,
    SIDE_SOUTH = 2'd3
  } side_e;

  typedef struct packed {
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [8:0] region_width;
    logic [8:0] region_height;
    logic [7:0] block_width;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rel_x;
    logic [7:0] rel_y;
    logic       cell_filled;
    logic       north_filled;
    logic       south_filled;
    logic       west_filled;
    logic       east_filled;
  } cell_item_t;

  typedef struct packed {
    side_e                 side;
    logic                  is_new;
    logic [EDGE_NUM_W-1:0] edge_number;
    logic [COORD_W-1:0]    start_x;
    logic [COORD_W-1:0]    start_y;
    logic [COORD_W-1:0]    end_x;
    logic [COORD_W-1:0]    end_y;
    logic                  ids_exhausted;
    logic                  last;
  } edge_event_t;

  // Horizontal edges left open by one row of the previous column.
  typedef struct packed {
    logic              north_set;
    logic              south_set;
    logic [EDGE_W-1:0] north_id;
    logic [EDGE_W-1:0] south_id;
  } col_entry_t;

  // Vertical edges left open by the cell just above.
  typedef struct packed {
    logic              west_set;
    logic              east_set;
    logic [EDGE_W-1:0] west_id;
    logic [EDGE_W-1:0] east_id;
  } above_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
    col_entry_t       data;
  } col_wr_t;

  typedef struct packed {
    logic                            active;
    above_t                          above;
    col_entry_t                      col;
    logic [CNT_W-1:0]                cnt;
    edge_event_t [N_SIDES-1:0]       ev;
    logic [$clog2(N_SIDES+1)-1:0]    n_ev;
  } cell_res_t;

endpackage

FILE: design/tee_col_store.sv
module tee_col_store import tee_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [ROW_W-1:0] rd_addr_i,
  input  col_wr_t          wr_i,
  input  logic             clear_i,
  output col_entry_t       rd_data_o
);

  col_entry_t            mem_q [MAX_ROWS];
  logic [MAX_ROWS-1:0]   valid_q;
  col_entry_t            rd_q;
  col_entry_t            byp_data_q;
  logic                  byp_hit_q;
  logic [ROW_W-1:0]      rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      byp_data_q <= wr_i.data;
    end
  end

  // A write landing in the same cycle as the read is forwarded, since the
  // memory returns the old contents then.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      byp_hit_q <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        byp_hit_q <= wr_i.en && (wr_i.addr == rd_addr_i);
        rd_addr_q <= rd_addr_i;
      end
    end
  end

  assign rd_data_o = !valid_q[rd_addr_q] ? '0 :
                     byp_hit_q ? byp_data_q : rd_q;

endmodule

FILE: design/tee_cell_eval.sv
module tee_cell_eval import tee_pkg::*; (
  input  cell_item_t       item_i,
  input  cfg_t             cfg_i,
  input  above_t           above_i,
  input  col_entry_t       col_i,
  input  logic [CNT_W-1:0] cnt_i,
  output cell_res_t        res_o
);

  function automatic logic [COORD_W-1:0] coord(input logic [9:0] tile,
                                               input logic [7:0] bw);
    logic [17:0] prod;
    prod = 18'(tile) * 18'(bw);
    return (prod > 18'(16'hFFFF)) ? 16'hFFFF : prod[COORD_W-1:0];
  endfunction

  logic                interior;
  above_t              above_eff;
  logic [9:0]          tx0, tx1, ty0, ty1;
  logic [COORD_W-1:0]  x0, x1, y0, y1;
  logic [N_SIDES-1:0]  need;
  logic [N_SIDES-1:0]  prev_set;
  logic [EDGE_W-1:0]   prev_id [N_SIDES];
  logic [COORD_W-1:0]  sx [N_SIDES];
  logic [COORD_W-1:0]  sy [N_SIDES];
  logic [COORD_W-1:0]  ex [N_SIDES];
  logic [COORD_W-1:0]  ey [N_SIDES];
  logic [N_SIDES-1:0]  side_set;
  logic [EDGE_W-1:0]   side_id [N_SIDES];

  assign interior = (item_i.rel_x != 8'd0) && (item_i.rel_y != 8'd0) &&
                    (32'(item_i.rel_y) < MAX_ROWS) &&
                    ((10'(item_i.rel_x) + 10'd2) <= 10'(cfg_i.region_width)) &&
                    ((10'(item_i.rel_y) + 10'd2) <= 10'(cfg_i.region_height));

  // The first cell of a column sees no vertical edges above it.
  assign above_eff = (item_i.rel_y == 8'd1) ? '0 : above_i;

  assign tx0 = 10'(cfg_i.origin_x) + 10'(item_i.rel_x);
  assign tx1 = tx0 + 10'd1;
  assign ty0 = 10'(cfg_i.origin_y) + 10'(item_i.rel_y);
  assign ty1 = ty0 + 10'd1;
  assign x0  = coord(tx0, cfg_i.block_width);
  assign x1  = coord(tx1, cfg_i.block_width);
  assign y0  = coord(ty0, cfg_i.block_width);
  assign y1  = coord(ty1, cfg_i.block_width);

  assign need[SIDE_WEST]  = item_i.cell_filled && !item_i.west_filled;
  assign need[SIDE_EAST]  = item_i.cell_filled && !item_i.east_filled;
  assign need[SIDE_NORTH] = item_i.cell_filled && !item_i.north_filled;
  assign need[SIDE_SOUTH] = item_i.cell_filled && !item_i.south_filled;

  assign prev_set[SIDE_WEST]  = above_eff.west_set;
  assign prev_set[SIDE_EAST]  = above_eff.east_set;
  assign prev_set[SIDE_NORTH] = col_i.north_set;
  assign prev_set[SIDE_SOUTH] = col_i.south_set;
  assign prev_id[SIDE_WEST]   = above_eff.west_id;
  assign prev_id[SIDE_EAST]   = above_eff.east_id;
  assign prev_id[SIDE_NORTH]  = col_i.north_id;
  assign prev_id[SIDE_SOUTH]  = col_i.south_id;

  // West and east edges run downwards, north and south edges rightwards.
  assign sx[SIDE_WEST]  = x0;  assign sy[SIDE_WEST]  = y0;
  assign ex[SIDE_WEST]  = x0;  assign ey[SIDE_WEST]  = y1;
  assign sx[SIDE_EAST]  = x1;  assign sy[SIDE_EAST]  = y0;
  assign ex[SIDE_EAST]  = x1;  assign ey[SIDE_EAST]  = y1;
  assign sx[SIDE_NORTH] = x0;  assign sy[SIDE_NORTH] = y0;
  assign ex[SIDE_NORTH] = x1;  assign ey[SIDE_NORTH] = y0;
  assign sx[SIDE_SOUTH] = x0;  assign sy[SIDE_SOUTH] = y1;
  assign ex[SIDE_SOUTH] = x1;  assign ey[SIDE_SOUTH] = y1;

  always_comb begin
    logic [2:0]       n_ok;
    logic [2:0]       slot;
    logic [CNT_W:0]   sum;
    logic             extend;
    logic             alloc;
    logic             exh;
    logic             ok;
    edge_event_t      ev_k;
    n_ok  = '0;
    slot  = '0;
    res_o = '0;
    for (int k = 0; k < N_SIDES; k++) begin
      extend = need[k] && prev_set[k];
      alloc  = need[k] && !prev_set[k];
      sum    = (CNT_W+1)'(cnt_i) + (CNT_W+1)'(n_ok);
      exh    = alloc && (32'(sum) >= MAX_EDGES);
      ok     = alloc && !exh;
      side_set[k] = extend || ok;
      side_id[k]  = extend ? prev_id[k] : sum[EDGE_W-1:0];
      ev_k.side          = side_e'(2'(k));
      ev_k.is_new        = alloc;
      ev_k.edge_number   = extend ? EDGE_NUM_W'(prev_id[k]) :
                           ok ? EDGE_NUM_W'(sum[EDGE_W-1:0]) : '0;
      ev_k.start_x       = alloc ? sx[k] : '0;
      ev_k.start_y       = alloc ? sy[k] : '0;
      ev_k.end_x         = ex[k];
      ev_k.end_y         = ey[k];
      ev_k.ids_exhausted = exh;
      ev_k.last          = 1'b0;
      if (need[k]) begin
        res_o.ev[slot[1:0]] = ev_k;
        slot = slot + 3'd1;
      end
      if (ok) begin
        n_ok = n_ok + 3'd1;
      end
    end
    if (slot != 3'd0) begin
      res_o.ev[2'(slot - 3'd1)].last = 1'b1;
    end
    res_o.active          = (item_i.cmd == CMD_CELL) && interior;
    res_o.n_ev            = slot;
    res_o.cnt             = cnt_i + CNT_W'(n_ok);
    res_o.above.west_set  = side_set[SIDE_WEST];
    res_o.above.east_set  = side_set[SIDE_EAST];
    res_o.above.west_id   = side_id[SIDE_WEST];
    res_o.above.east_id   = side_id[SIDE_EAST];
    res_o.col.north_set   = side_set[SIDE_NORTH];
    res_o.col.south_set   = side_set[SIDE_SOUTH];
    res_o.col.north_id    = side_id[SIDE_NORTH];
    res_o.col.south_id    = side_id[SIDE_SOUTH];
  end

endmodule

FILE: design/tee_event_queue.sv
module tee_event_queue import tee_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  edge_event_t [N_SIDES-1:0]    ev_i,
  input  logic [$clog2(N_SIDES+1)-1:0] n_ev_i,
  output logic                         can_load_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output edge_event_t                  out_ev_o
);

  localparam int N_W = $clog2(N_SIDES + 1);

  edge_event_t    q_q [N_SIDES];
  logic [N_W-1:0] count_q;
  edge_event_t    out_q;
  logic           out_valid_q;
  logic           move;

  assign move       = (count_q != '0) && (!out_valid_q || out_ready_i);
  assign can_load_o = (count_q == '0) || ((count_q == N_W'(1)) && move);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < N_SIDES; i++) begin
        q_q[i] <= ev_i[i];
      end
    end else if (move) begin
      for (int i = 0; i < N_SIDES - 1; i++) begin
        q_q[i] <= q_q[i+1];
      end
    end
    if (move) begin
      out_q <= q_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        count_q <= n_ev_i;
      end else if (move) begin
        count_q <= count_q - N_W'(1);
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ev_o    = out_q;

endmodule

FILE: design/tile_edge_extractor.sv
// Tile edge extractor: turns the solid cells of a tile region into edge events.
// Items enter on the in channel (in_valid_i / in_ready_o). A start-region
// item (cmd 0) clears the open-edge state and the edge counter; a cell item
// (cmd 1) carries one interior cell, column by column and top to bottom,
// with its own filled bit and those of its four neighbours. Each filled cell
// gives an edge event per empty neighbour, west, east, north, south in order,
// on the out channel (out_valid_o / out_ready_i), the final one marked by
// last_o. Registers are written on the cfg channel, which is always ready,
// and must only change while the block is idle.
// The first event of a cell passes from the item register through the event
// queue into the output register. An item is taken every cycle while it
// gives no events; a cell's events share the single out channel, the
// four-entry event queue draining one event a cycle into the output
// register while the receiver is ready.
// The open horizontal edges of the previous column sit in a row memory
// read when an item is accepted; one valid flip-flop per row makes a region
// start take effect at once, with no clearing pass.
// Reset restores the register defaults and empties every pipeline stage.
// When the receiver stalls, events wait in the queue; until it is empty or
// sending its last event, a cell with events waits and in_ready_o stays low.
module tile_edge_extractor import tee_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [7:0]            rel_x_i,
  input  logic [7:0]            rel_y_i,
  input  logic                  cell_filled_i,
  input  logic                  north_filled_i,
  input  logic                  south_filled_i,
  input  logic                  west_filled_i,
  input  logic                  east_filled_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            side_o,
  output logic                  is_new_o,
  output logic [EDGE_NUM_W-1:0] edge_number_o,
  output logic [COORD_W-1:0]    start_x_o,
  output logic [COORD_W-1:0]    start_y_o,
  output logic [COORD_W-1:0]    end_x_o,
  output logic [COORD_W-1:0]    end_y_o,
  output logic                  ids_exhausted_o,
  output logic                  last_o
);

  cfg_t             cfg_q;
  cell_item_t       s1_q;
  logic             s1_valid_q;
  above_t           above_q;
  logic [CNT_W-1:0] cnt_q;

  logic             in_accept;
  logic             proc;
  logic             is_start;
  logic             q_load;
  logic             q_can_load;
  col_entry_t       col_rd;
  col_wr_t          col_wr;
  cell_res_t        res;
  edge_event_t      out_ev;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= 8'd0;
      cfg_q.origin_y      <= 8'd0;
      cfg_q.region_width  <= 9'd32;
      cfg_q.region_height <= 9'd24;
      cfg_q.block_width   <= 8'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data_i[7:0];
        CFG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data_i[7:0];
        CFG_REGION_WIDTH:  cfg_q.region_width  <= cfg_data_i[8:0];
        CFG_REGION_HEIGHT: cfg_q.region_height <= cfg_data_i[8:0];
        CFG_BLOCK_WIDTH:   cfg_q.block_width   <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // A held item is resolved once its events fit into the queue; start
  // items, ignored cells and cells without events need no queue room.
  assign is_start   = (s1_q.cmd == CMD_START);
  assign proc       = s1_valid_q &&
                      (is_start || !res.active || (res.n_ev == '0) || q_can_load);
  assign q_load     = proc && res.active && (res.n_ev != '0);
  assign in_ready_o = !s1_valid_q || proc;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.cmd          <= cmd_i;
      s1_q.rel_x        <= rel_x_i;
      s1_q.rel_y        <= rel_y_i;
      s1_q.cell_filled  <= cell_filled_i;
      s1_q.north_filled <= north_filled_i;
      s1_q.south_filled <= south_filled_i;
      s1_q.west_filled  <= west_filled_i;
      s1_q.east_filled  <= east_filled_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      above_q    <= '0;
      cnt_q      <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (proc) begin
        s1_valid_q <= 1'b0;
      end
      if (proc) begin
        if (is_start) begin
          above_q.west_set <= 1'b0;
          above_q.east_set <= 1'b0;
          cnt_q            <= '0;
        end else if (res.active) begin
          above_q <= res.above;
          cnt_q   <= res.cnt;
        end
      end
    end
  end

  assign col_wr.en   = proc && res.active;
  assign col_wr.addr = ROW_W'(s1_q.rel_y);
  assign col_wr.data = res.col;

  tee_col_store u_col_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (ROW_W'(rel_y_i)),
    .wr_i      (col_wr),
    .clear_i   (proc && is_start),
    .rd_data_o (col_rd)
  );

  tee_cell_eval u_cell_eval (
    .item_i  (s1_q),
    .cfg_i   (cfg_q),
    .above_i (above_q),
    .col_i   (col_rd),
    .cnt_i   (cnt_q),
    .res_o   (res)
  );

  tee_event_queue u_event_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (q_load),
    .ev_i        (res.ev),
    .n_ev_i      (res.n_ev),
    .can_load_o  (q_can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_ev_o    (out_ev)
  );

  assign side_o          = out_ev.side;
  assign is_new_o        = out_ev.is_new;
  assign edge_number_o   = out_ev.edge_number;
  assign start_x_o       = out_ev.start_x;
  assign start_y_o       = out_ev.start_y;
  assign end_x_o         = out_ev.end_x;
  assign end_y_o         = out_ev.end_y;
  assign ids_exhausted_o = out_ev.ids_exhausted;
  assign last_o          = out_ev.last;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_EDGES)
    else $error("edge counter beyond the id space");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && is_start |=> (cnt_q == '0) && !above_q.west_set && !above_q.east_set)
    else $error("region start did not clear the edge state");

  a_held_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !proc |=> s1_valid_q && $stable(s1_q))
    else $error("held cell item lost or changed");

  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_load |-> $countones({res.ev[0].last, res.ev[1].last,
                           res.ev[2].last, res.ev[3].last}) == 1)
    else $error("event group without exactly one last marker");
`endif

endmodule
